// ----- rtl/pfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_pkg: shared types and codes of the protobuf field serializer
// Opcodes, wire types, field widths and the byte frame that the encoder
// hands to the byte shifter.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int unsigned OpcodeW = 3;
  localparam int unsigned FieldW  = 29;
  localparam int unsigned ValueW  = 64;

  localparam int unsigned TagBytes = 5;   // 32-bit tag in 7-bit groups
  localparam int unsigned PayBytes = 10;  // 64-bit varint in 7-bit groups

  typedef enum logic [OpcodeW-1:0] {
    OpTagVarint   = 3'd0,
    OpTagFixed32  = 3'd1,
    OpTagLength   = 3'd2,
    OpBareVarint  = 3'd3,
    OpBareFixed32 = 3'd4,
    OpRawByte     = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    WtVarint  = 3'd0,
    WtLen     = 3'd2,
    WtFixed32 = 3'd5
  } wt_code_e;

  localparam logic [7:0] Low7Mask = 8'h7F;
  localparam logic [7:0] ContBit  = 8'h80;

  // All bytes of one item, tag part and payload part, with their counts.
  typedef struct packed {
    logic [TagBytes-1:0][7:0] tag_bytes;
    logic [2:0]               tag_len;
    logic [PayBytes-1:0][7:0] pay_bytes;
    logic [3:0]               pay_len;
  } frame_t;

endpackage

// ----- rtl/pfs_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_encoder: command to byte frame
// Builds the tag varint and the payload bytes of one registered command.
// ----------------------------------------------------------------------------
module pfs_encoder (
  input  logic [pfs_pkg::OpcodeW-1:0] opcode_i,
  input  logic [pfs_pkg::FieldW-1:0]  field_number_i,
  input  logic [pfs_pkg::ValueW-1:0]  value_i,
  output pfs_pkg::frame_t             frame_o
);

  logic [7*pfs_pkg::TagBytes-1:0] tag_ext;
  logic [7*pfs_pkg::PayBytes-1:0] val_ext;
  logic [2:0]                     wt_sel;
  logic                           has_tag;
  logic [pfs_pkg::TagBytes-1:0][7:0] tag_enc;
  logic [pfs_pkg::PayBytes-1:0][7:0] val_enc;
  logic [2:0]                     tag_enc_len;
  logic [3:0]                     val_enc_len;

  always_comb begin
    has_tag = 1'b0;
    wt_sel  = pfs_pkg::WtVarint;
    case (opcode_i)
      pfs_pkg::OpTagVarint: begin
        has_tag = 1'b1;
        wt_sel  = pfs_pkg::WtVarint;
      end
      pfs_pkg::OpTagFixed32: begin
        has_tag = 1'b1;
        wt_sel  = pfs_pkg::WtFixed32;
      end
      pfs_pkg::OpTagLength: begin
        has_tag = 1'b1;
        wt_sel  = pfs_pkg::WtLen;
      end
      default: begin
        has_tag = 1'b0;
        wt_sel  = pfs_pkg::WtVarint;
      end
    endcase
  end

  assign tag_ext = {3'b000, field_number_i, wt_sel};
  assign val_ext = {6'b000000, value_i};

  // Length of a varint is the index of the highest nonzero group plus one.
  always_comb begin
    tag_enc_len = 3'd1;
    for (int i = 1; i < pfs_pkg::TagBytes; i++) begin
      if (tag_ext[7*i +: 7] != 7'd0) tag_enc_len = 3'(i + 1);
    end
    val_enc_len = 4'd1;
    for (int i = 1; i < pfs_pkg::PayBytes; i++) begin
      if (val_ext[7*i +: 7] != 7'd0) val_enc_len = 4'(i + 1);
    end
  end

  // Each byte carries its group and a continuation bit when more follow.
  always_comb begin
    for (int i = 0; i < pfs_pkg::TagBytes; i++) begin
      tag_enc[i] = {(3'(i + 1) < tag_enc_len), tag_ext[7*i +: 7]};
    end
    for (int i = 0; i < pfs_pkg::PayBytes; i++) begin
      val_enc[i] = {(4'(i + 1) < val_enc_len), val_ext[7*i +: 7]};
    end
  end

  always_comb begin
    frame_o.tag_bytes = tag_enc;
    frame_o.tag_len   = has_tag ? tag_enc_len : 3'd0;
    frame_o.pay_bytes = val_enc;
    frame_o.pay_len   = 4'd0;
    case (opcode_i)
      pfs_pkg::OpTagVarint, pfs_pkg::OpTagLength, pfs_pkg::OpBareVarint: begin
        frame_o.pay_len = val_enc_len;
      end
      pfs_pkg::OpTagFixed32, pfs_pkg::OpBareFixed32: begin
        for (int i = 0; i < 4; i++) frame_o.pay_bytes[i] = value_i[8*i +: 8];
        frame_o.pay_len = 4'd4;
      end
      pfs_pkg::OpRawByte: begin
        frame_o.pay_bytes[0] = value_i[7:0];
        frame_o.pay_len      = 4'd1;
      end
      default: begin
        frame_o.tag_len = 3'd0;
        frame_o.pay_len = 4'd0;
      end
    endcase
  end

endmodule

// ----- rtl/pfs_byte_shifter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_byte_shifter: frame buffer and byte output
// Holds one frame and sends its tag bytes, then its payload bytes, one per
// cycle.
// ----------------------------------------------------------------------------
module pfs_byte_shifter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  pfs_pkg::frame_t frame_i,
  output logic            free_o,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            last_byte_o
);

  logic [pfs_pkg::TagBytes-1:0][7:0] tag_q, tag_d;
  logic [pfs_pkg::PayBytes-1:0][7:0] pay_q, pay_d;
  logic [2:0] tag_len_q, tag_len_d;
  logic [3:0] pay_len_q, pay_len_d;
  logic [4:0] remaining;

  assign remaining   = {2'b00, tag_len_q} + {1'b0, pay_len_q};
  assign out_valid_o = (remaining != 5'd0);
  assign last_byte_o = (remaining == 5'd1);
  assign out_byte_o  = (tag_len_q != 3'd0) ? tag_q[0] : pay_q[0];
  assign free_o      = (remaining <= 5'd1);

  always_comb begin
    tag_d     = tag_q;
    pay_d     = pay_q;
    tag_len_d = tag_len_q;
    pay_len_d = pay_len_q;
    if (load_i) begin
      tag_d     = frame_i.tag_bytes;
      pay_d     = frame_i.pay_bytes;
      tag_len_d = frame_i.tag_len;
      pay_len_d = frame_i.pay_len;
    end else if (tag_len_q != 3'd0) begin
      tag_d     = {8'h00, tag_q[pfs_pkg::TagBytes-1:1]};
      tag_len_d = tag_len_q - 3'd1;
    end else if (pay_len_q != 4'd0) begin
      pay_d     = {8'h00, pay_q[pfs_pkg::PayBytes-1:1]};
      pay_len_d = pay_len_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_len_q <= 3'd0;
      pay_len_q <= 4'd0;
    end else begin
      tag_len_q <= tag_len_d;
      pay_len_q <= pay_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
    pay_q <= pay_d;
  end

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o) else $error("frame loaded over unsent bytes");

  a_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (remaining > 5'd1) |=> (remaining == $past(remaining) - 5'd1))
    else $error("byte count did not step down by one");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_byte_o && !load_i) |=> !out_valid_o)
    else $error("bytes sent after the last byte of an item");

  a_len_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag_len_q <= 3'd5) && (pay_len_q <= 4'd10))
    else $error("frame length out of range");

endmodule

// ----- rtl/protobuf_field_serializer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// protobuf_field_serializer: protobuf wire-format byte encoder
// Order: start fills the command register; its frame then enters the shifter.
// Output: an item has 1 to 15 bytes, sent one byte per cycle out of the frame
//   buffer; an unused opcode sends no bytes.
// Reset: rst_ni clears the command flag and frame counts; no bytes are pending.
// The receiver cannot stall: each byte is shown for exactly one cycle.
// ----------------------------------------------------------------------------
//
// Structure: a command register captures the item at start. The encoder
// turns the registered command into a frame (tag varint plus payload bytes)
// in one pass, and the frame is loaded into the byte shifter as soon as the
// shifter is on its last byte or empty. That lets the next item follow the
// last byte of the previous one without a gap. busy_o is high only while a
// command waits in the register for the shifter to free up.
module protobuf_field_serializer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [pfs_pkg::OpcodeW-1:0] opcode_i,
  input  logic [pfs_pkg::FieldW-1:0]  field_number_i,
  input  logic [pfs_pkg::ValueW-1:0]  value_i,
  output logic                        out_valid_o,
  output logic [7:0]                  out_byte_o,
  output logic                        last_byte_o
);

  logic                        cmd_valid_q, cmd_valid_d;
  logic [pfs_pkg::OpcodeW-1:0] opcode_q;
  logic [pfs_pkg::FieldW-1:0]  field_q;
  logic [pfs_pkg::ValueW-1:0]  value_q;
  logic                        accept;
  logic                        load;
  logic                        free;
  pfs_pkg::frame_t             frame;

  // A waiting command moves into the shifter whenever the shifter frees up,
  // so the command register is open again in that same cycle.
  assign load        = cmd_valid_q && free;
  assign busy_o      = cmd_valid_q && !free;
  assign accept      = start_i && !busy_o;
  assign cmd_valid_d = accept || (cmd_valid_q && !free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  // Payload of the command register needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      opcode_q <= opcode_i;
      field_q  <= field_number_i;
      value_q  <= value_i;
    end
  end

  pfs_encoder u_encoder (
    .opcode_i       (opcode_q),
    .field_number_i (field_q),
    .value_i        (value_q),
    .frame_o        (frame)
  );

  pfs_byte_shifter u_shifter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .frame_i     (frame),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

  a_busy_holds_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> cmd_valid_q) else $error("waiting command lost");

  a_accept_fills_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> cmd_valid_q) else $error("accepted item not registered");

  a_busy_means_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (out_valid_o && !last_byte_o))
    else $error("busy without bytes in flight");

endmodule
